[rtl/rek_pkg.sv]
`default_nettype none

package rek_pkg;

  // Width of the lockout counter and of the debounce register
  localparam int unsigned LOCKOUT_WIDTH = 10;

  // Reset value of the debounce register
  localparam logic [LOCKOUT_WIDTH-1:0] DEBOUNCE_RESET = LOCKOUT_WIDTH'(10);

  // Rotation event codes
  typedef enum logic [2:0] {
    ROT_NONE      = 3'd0,
    ROT_UP        = 3'd1,
    ROT_DOWN      = 3'd2,
    ROT_PAGE_UP   = 3'd3,
    ROT_PAGE_DOWN = 3'd4
  } rot_evt_t;

  // Button event codes
  typedef enum logic [1:0] {
    BTN_NONE    = 2'd0,
    BTN_PRESS   = 2'd1,
    BTN_RELEASE = 2'd2
  } btn_evt_t;

  // Decoder state carried from one sample to the next
  typedef struct packed {
    logic                     primed;
    logic                     prev_a;
    logic                     prev_b;
    logic                     button_level;
    logic [LOCKOUT_WIDTH-1:0] lockout_count;
  } rek_state_t;

endpackage

`default_nettype wire

[rtl/rek_step.sv]
`default_nettype none

module rek_step (
  input  rek_pkg::rek_state_t                   state,
  input  logic [rek_pkg::LOCKOUT_WIDTH-1:0]     debounce,
  input  logic                                  enc_a,
  input  logic                                  enc_b,
  input  logic                                  button_raw,
  output rek_pkg::rek_state_t                   state_next,
  output rek_pkg::rot_evt_t                     rot_evt,
  output rek_pkg::btn_evt_t                     btn_evt
);
  import rek_pkg::*;

  logic signed [2:0] da;
  logic signed [2:0] db;
  logic signed [2:0] delta;
  logic              coarse_up;
  logic              coarse_down;

  // Quadrature position change from old and new A/B levels
  always_comb begin
    da    = $signed({2'b00, enc_a}) - $signed({2'b00, state.prev_a});
    db    = $signed({2'b00, enc_b}) - $signed({2'b00, state.prev_b});
    delta = enc_b ? -da : da;
    if (enc_a) begin
      delta = delta + db;
    end else begin
      delta = delta - db;
    end
  end

  // Low-resolution change: B moving while A is low
  assign coarse_up   = !enc_a && !enc_b && state.prev_b;
  assign coarse_down = !enc_a && enc_b && !state.prev_b;

  // Pick events and advance state
  always_comb begin
    state_next = state;
    rot_evt    = ROT_NONE;
    btn_evt    = BTN_NONE;
    if (!state.primed) begin
      state_next.primed       = 1'b1;
      state_next.prev_a       = enc_a;
      state_next.prev_b       = enc_b;
      state_next.button_level = button_raw;
    end else begin
      state_next.prev_a = enc_a;
      state_next.prev_b = enc_b;
      if (button_raw) begin
        if (delta > 3'sd0) begin
          rot_evt = ROT_PAGE_UP;
        end else if (delta < 3'sd0) begin
          rot_evt = ROT_PAGE_DOWN;
        end
      end else begin
        if (coarse_up) begin
          rot_evt = ROT_UP;
        end else if (coarse_down) begin
          rot_evt = ROT_DOWN;
        end
      end
      // Hold off the switch during lockout, else look for an edge
      if (state.lockout_count != '0) begin
        state_next.lockout_count = state.lockout_count - LOCKOUT_WIDTH'(1);
      end else if (button_raw != state.button_level) begin
        btn_evt                  = button_raw ? BTN_PRESS : BTN_RELEASE;
        state_next.button_level  = button_raw;
        state_next.lockout_count = debounce;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/rotary_encoder_key_events_top.sv]
`default_nettype none
// Rotary encoder and push-switch event decoder.
// Results are loaded into the output register on the sample beat that makes them.
// Throughput: one sample per cycle while the output register is empty or being taken.
// Reset (synchronous, rst high): state cleared, output empty, debounce register
// back to 10; the first sample after reset only primes the stored levels.

module rotary_encoder_key_events_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rek_pkg::LOCKOUT_WIDTH-1:0] debounce_ticks,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              enc_a,
  input  wire logic                              enc_b,
  input  wire logic                              button_raw,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             rotation_event,
  output logic [1:0]                             button_event
);
  import rek_pkg::*;

  logic [LOCKOUT_WIDTH-1:0] debounce;
  rek_state_t               state;
  rek_state_t               state_next;
  rot_evt_t                 rot_evt;
  btn_evt_t                 btn_evt;
  logic                     in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Hold the debounce register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= DEBOUNCE_RESET;
    end else if (cfg_valid) begin
      debounce <= debounce_ticks;
    end
  end

  rek_step u_step (
    .state      (state),
    .debounce   (debounce),
    .enc_a      (enc_a),
    .enc_b      (enc_b),
    .button_raw (button_raw),
    .state_next (state_next),
    .rot_evt    (rot_evt),
    .btn_evt    (btn_evt)
  );

  // Advance decoder state on each sample beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register: load on a sample beat, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rotation_event <= rot_evt;
      button_event   <= btn_evt;
    end
  end

  // The priming sample gives no events
  a_prime_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !state.primed) |=>
      (rotation_event == ROT_NONE && button_event == BTN_NONE))
    else $error("priming sample produced an event");

  // No button event while the lockout runs
  a_lockout_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_fire && state.primed && state.lockout_count != '0) |=>
      (button_event == BTN_NONE))
    else $error("button event during lockout");

  // A button event loads the lockout from the debounce register
  a_lockout_load: assert property (@(posedge clk) disable iff (rst)
    (in_fire && btn_evt != BTN_NONE) |=>
      (state.lockout_count == $past(debounce)))
    else $error("lockout not loaded after button edge");

  // An empty output register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire
